>>> hdl/bclru_pkg.sv
`timescale 1ns / 1ps
// bclru_pkg: shared types and codes for the block buffer cache
// no dependencies; used by every module of the cache
package bclru_pkg;

   localparam int NUM_SLOTS_DEF = 32;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   // request actions
   localparam logic [1:0] ACT_READ    = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_PIN     = 2'd2;
   localparam logic [1:0] ACT_UNPIN   = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOFREE = 2'd1;
   localparam logic [1:0] STAT_UNDER  = 2'd2;
   localparam logic [1:0] STAT_SAT    = 2'd3;

   // one slot as seen at the slot ram ports
   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic [7:0]  count;
      logic        valid;
   } slot_entry_type;

   // write enables of the slot ram
   typedef struct packed {
      logic tag;
      logic count;
      logic valid;
   } slot_we_type;

endpackage

>>> hdl/bclru_order_ram.sv
`timescale 1ns / 1ps
// bclru_order_ram: recency order memory, position 0 is most recent
// depends on bclru_pkg for the default depth
module bclru_order_ram #(
   parameter int NUM_SLOTS = bclru_pkg::NUM_SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output logic [$clog2(NUM_SLOTS)-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_data
);
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   logic [SLOT_W-1:0]    order_ram_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] written_ff;
   logic [SLOT_W-1:0]    rd_raw_ff;
   logic [SLOT_W-1:0]    rd_dflt_ff;
   logic                 rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         order_ram_ff[wr_addr] <= wr_data;
      end
      rd_raw_ff  <= order_ram_ff[rd_addr];
      rd_dflt_ff <= LAST_SLOT - rd_addr;
   end

   // unwritten positions read as the reset order
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data = rd_written_ff ? rd_raw_ff : rd_dflt_ff;

endmodule

>>> hdl/bclru_slot_ram.sv
`timescale 1ns / 1ps
// bclru_slot_ram: per-slot tag, reference count and valid mark
// depends on bclru_pkg for slot_entry_type and slot_we_type
module bclru_slot_ram #(
   parameter int NUM_SLOTS = bclru_pkg::NUM_SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output bclru_pkg::slot_entry_type    rd_data,
   input  bclru_pkg::slot_we_type       wr_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  bclru_pkg::slot_entry_type    wr_data
);
   import bclru_pkg::*;

   logic [39:0]          tag_ram_ff [NUM_SLOTS];
   logic [7:0]           cnt_ram_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] tag_written_ff;
   logic [NUM_SLOTS-1:0] cnt_written_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [39:0]          rd_tag_ff;
   logic [7:0]           rd_cnt_ff;
   logic                 rd_tag_ok_ff;
   logic                 rd_cnt_ok_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en.tag) begin
         tag_ram_ff[wr_addr] <= {wr_data.device, wr_data.block};
      end
      if (wr_en.count) begin
         cnt_ram_ff[wr_addr] <= wr_data.count;
      end
      rd_tag_ff <= tag_ram_ff[rd_addr];
      rd_cnt_ff <= cnt_ram_ff[rd_addr];
   end

   // never written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_written_ff <= '0;
         cnt_written_ff <= '0;
         valid_ff       <= '0;
         rd_tag_ok_ff   <= 1'b0;
         rd_cnt_ok_ff   <= 1'b0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (wr_en.tag) begin
            tag_written_ff[wr_addr] <= 1'b1;
         end
         if (wr_en.count) begin
            cnt_written_ff[wr_addr] <= 1'b1;
         end
         if (wr_en.valid) begin
            valid_ff[wr_addr] <= wr_data.valid;
         end
         rd_tag_ok_ff <= tag_written_ff[rd_addr];
         rd_cnt_ok_ff <= cnt_written_ff[rd_addr];
         rd_valid_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data.device = rd_tag_ok_ff ? rd_tag_ff[39:32] : 8'd0;
   assign rd_data.block  = rd_tag_ok_ff ? rd_tag_ff[31:0] : 32'd0;
   assign rd_data.count  = rd_cnt_ok_ff ? rd_cnt_ff : 8'd0;
   assign rd_data.valid  = rd_valid_ff;

endmodule

>>> hdl/block_cache_lru_refcount.sv
`timescale 1ns / 1ps
// block_cache_lru_refcount: top level of the block buffer cache with lru reuse
// depends on bclru_pkg, bclru_order_ram, bclru_slot_ram
//
//   channel   ports                                  handshake
//   --------  -------------------------------------  -------------------------
//   request   req_action, req_device_id,             word taken when start is
//             req_block_number, req_slot_index       high and busy is low
//   response  rsp_slot, rsp_hit, rsp_needs_fill,     one-cycle strobe on
//             rsp_status                             rsp_valid, never stalled
//
// a read scans the recency order from the most recent end; a miss runs the full
// hit scan and then the free scan from the least recent end. the scans issue one
// order ram read and one slot ram read per cycle.
// pin, unpin and release of a slot in range read its count and answer from the
// count state; a release that drops the count to zero adds the move to front.
// busy is high while a word is worked on; the next word can be taken in the
// cycle its predecessor's strobe is shown. reset clears the recency order to
// slots NUM_SLOTS-1 down to 0 and all tags and counts to zero at once, with
// no clearing pass. the receiver cannot stall the response.
module block_cache_lru_refcount #(
   parameter int NUM_SLOTS = bclru_pkg::NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_device_id,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_slot_index,
   output logic        rsp_valid,
   output logic [4:0]  rsp_slot,
   output logic        rsp_hit,
   output logic        rsp_needs_fill,
   output logic [1:0]  rsp_status
);
   import bclru_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0]  N_CNT     = CNT_W'(NUM_SLOTS);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(NUM_SLOTS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
   localparam logic [1:0] ST_MOVE  = 2'd3;

   logic [1:0]        state_ff, state_in;

   // captured request word
   logic [1:0]        act_ff, act_in;
   logic [7:0]        dev_ff, dev_in;
   logic [31:0]       blk_ff, blk_in;
   logic [4:0]        idx_ff, idx_in;

   // scan and move pipeline
   logic              hitscan_ff, hitscan_in;   // 1: tag scan, 0: free slot scan
   logic [CNT_W-1:0]  issue_pos_ff, issue_pos_in;
   logic [CNT_W-1:0]  cmp_pos_ff, cmp_pos_in;
   logic              o_vld_ff, o_vld_in;       // order ram data valid
   logic [SLOT_W-1:0] o_pos_ff, o_pos_in;
   logic              s_vld_ff, s_vld_in;       // slot ram data valid
   logic [SLOT_W-1:0] s_slot_ff, s_slot_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;         // carry of the move to front

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [4:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_fill_ff, rsp_fill_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // memory ports
   logic [SLOT_W-1:0] order_rd_addr;
   logic [SLOT_W-1:0] order_rd_data;
   logic              order_we;
   logic [SLOT_W-1:0] order_wr_addr;
   logic [SLOT_W-1:0] order_wr_data;
   logic [SLOT_W-1:0] slot_rd_addr;
   slot_entry_type    slot_rd;
   slot_we_type       slot_we;
   logic [SLOT_W-1:0] slot_wr_addr;
   slot_entry_type    slot_wr;

   // shared compare unit: tag match in the hit scan, zero count in the free scan
   logic [39:0]       cmp_lhs;
   logic [39:0]       cmp_rhs;
   logic              cmp_eq;

   logic              accept;
   logic              issue;
   logic              last_cmp;
   logic [SLOT_W-1:0] idx_slot;

   assign accept   = start && (state_ff == ST_IDLE);
   assign idx_slot = SLOT_W'(idx_ff);
   assign last_cmp = (cmp_pos_ff == LAST_CNT);
   assign issue    = (issue_pos_ff != N_CNT);

   assign cmp_lhs = hitscan_ff ? {slot_rd.device, slot_rd.block} : {32'd0, slot_rd.count};
   assign cmp_rhs = hitscan_ff ? {dev_ff, blk_ff} : 40'd0;
   assign cmp_eq  = (cmp_lhs == cmp_rhs);

   bclru_order_ram #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_order_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (order_rd_addr),
      .rd_data (order_rd_data),
      .wr_en   (order_we),
      .wr_addr (order_wr_addr),
      .wr_data (order_wr_data)
   );

   bclru_slot_ram #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd),
      .wr_en   (slot_we),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr)
   );

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      idx_in        = idx_ff;
      hitscan_in    = hitscan_ff;
      issue_pos_in  = issue_pos_ff;
      cmp_pos_in    = cmp_pos_ff;
      o_vld_in      = 1'b0;
      o_pos_in      = o_pos_ff;
      s_vld_in      = 1'b0;
      s_slot_in     = s_slot_ff;
      prev_in       = prev_ff;

      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;

      order_rd_addr = '0;
      order_we      = 1'b0;
      order_wr_addr = o_pos_ff;
      order_wr_data = prev_ff;
      slot_rd_addr  = idx_slot;
      slot_we       = '0;
      slot_wr_addr  = idx_slot;
      slot_wr       = slot_rd;

      case (state_ff)
         ST_IDLE: begin
            // start the slot read at once for release, pin and unpin
            slot_rd_addr = SLOT_W'(req_slot_index);
            if (accept) begin
               act_in       = req_action;
               dev_in       = req_device_id;
               blk_in       = req_block_number;
               idx_in       = req_slot_index;
               hitscan_in   = 1'b1;
               issue_pos_in = '0;
               cmp_pos_in   = '0;
               if (req_action == ACT_READ) begin
                  state_in = ST_SCAN;
               end else if (int'(req_slot_index) < NUM_SLOTS) begin
                  state_in = ST_COUNT;
               end else begin
                  // slot out of range: ignored, echoed back
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = req_slot_index;
                  rsp_hit_in    = 1'b0;
                  rsp_fill_in   = 1'b0;
                  rsp_status_in = STAT_OK;
               end
            end
         end

         ST_SCAN: begin
            order_rd_addr = hitscan_ff ? issue_pos_ff[SLOT_W-1:0]
                                       : LAST_SLOT - issue_pos_ff[SLOT_W-1:0];
            slot_rd_addr  = order_rd_data;
            slot_wr_addr  = s_slot_ff;
            if (s_vld_ff && (cmp_eq || last_cmp)) begin
               if (cmp_eq && hitscan_ff) begin
                  // hit
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = 5'(s_slot_ff);
                  rsp_hit_in   = 1'b1;
                  if (slot_rd.count == COUNT_MAX) begin
                     rsp_fill_in   = 1'b0;
                     rsp_status_in = STAT_SAT;
                  end else begin
                     slot_we.count = 1'b1;
                     slot_we.valid = 1'b1;
                     slot_wr.count = slot_rd.count + 8'd1;
                     slot_wr.valid = 1'b1;
                     rsp_fill_in   = !slot_rd.valid;
                     rsp_status_in = STAT_OK;
                  end
               end else if (cmp_eq) begin
                  // least recent free slot: retag and hand out for fill
                  state_in       = ST_IDLE;
                  slot_we        = '{tag: 1'b1, count: 1'b1, valid: 1'b1};
                  slot_wr.device = dev_ff;
                  slot_wr.block  = blk_ff;
                  slot_wr.count  = 8'd1;
                  slot_wr.valid  = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_slot_in    = 5'(s_slot_ff);
                  rsp_hit_in     = 1'b0;
                  rsp_fill_in    = 1'b1;
                  rsp_status_in  = STAT_OK;
               end else if (hitscan_ff) begin
                  // no tag match: rescan for a free slot from the lru end
                  hitscan_in   = 1'b0;
                  issue_pos_in = '0;
                  cmp_pos_in   = '0;
               end else begin
                  state_in      = ST_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = 5'd0;
                  rsp_hit_in    = 1'b0;
                  rsp_fill_in   = 1'b0;
                  rsp_status_in = STAT_NOFREE;
               end
            end else begin
               issue_pos_in = issue_pos_ff + CNT_W'(issue);
               cmp_pos_in   = cmp_pos_ff + CNT_W'(s_vld_ff);
               o_vld_in     = issue;
               s_vld_in     = o_vld_ff;
               s_slot_in    = order_rd_data;
            end
         end

         ST_COUNT: begin
            rsp_slot_in   = idx_ff;
            rsp_hit_in    = 1'b0;
            rsp_fill_in   = 1'b0;
            rsp_status_in = STAT_OK;
            issue_pos_in  = '0;
            prev_in       = idx_slot;
            if (act_ff == ACT_PIN) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (slot_rd.count == COUNT_MAX) begin
                  rsp_status_in = STAT_SAT;
               end else begin
                  slot_we.count = 1'b1;
                  slot_wr.count = slot_rd.count + 8'd1;
               end
            end else if (slot_rd.count == 8'd0) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_UNDER;
            end else begin
               slot_we.count = 1'b1;
               slot_wr.count = slot_rd.count - 8'd1;
               if (act_ff == ACT_RELEASE && slot_rd.count == 8'd1) begin
                  // last reference gone: slot becomes most recent
                  state_in = ST_MOVE;
               end else begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end

         ST_MOVE: begin
            // shift positions down by one until the slot's old place
            order_rd_addr = issue_pos_ff[SLOT_W-1:0];
            if (o_vld_ff) begin
               order_we = 1'b1;
            end
            if (o_vld_ff && (order_rd_data == idx_slot)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               if (o_vld_ff) begin
                  prev_in = order_rd_data;
               end
               issue_pos_in = issue_pos_ff + CNT_W'(issue);
               o_vld_in     = issue;
               o_pos_in     = issue_pos_ff[SLOT_W-1:0];
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hitscan_ff   <= 1'b1;
         issue_pos_ff <= '0;
         cmp_pos_ff   <= '0;
         o_vld_ff     <= 1'b0;
         s_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hitscan_ff   <= hitscan_in;
         issue_pos_ff <= issue_pos_in;
         cmp_pos_ff   <= cmp_pos_in;
         o_vld_ff     <= o_vld_in;
         s_vld_ff     <= s_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      idx_ff        <= idx_in;
      o_pos_ff      <= o_pos_in;
      s_slot_ff     <= s_slot_in;
      prev_ff       <= prev_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_needs_fill = rsp_fill_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> hdl/bclru_checker.sv
`timescale 1ns / 1ps
// bclru_checker: port-level checks of the block buffer cache, bound to the top
// depends on bclru_pkg for the status codes
module bclru_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [4:0] rsp_slot,
   input logic       rsp_hit,
   input logic       rsp_needs_fill,
   input logic [1:0] rsp_status
);
   import bclru_pkg::*;

   // a response only shows once the work is done
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response word while busy");

   // finishing a word always answers it
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response word");

   // an accepted word either starts work or is answered at once
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither worked on nor answered");

   // no free slot answers a fixed word
   a_nofree: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_NOFREE)
         |-> (rsp_slot == 5'd0 && !rsp_hit && !rsp_needs_fill))
      else $error("malformed no-free-slot response");

   // a fill is only requested on a successful read
   a_fill_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_needs_fill) |-> (rsp_status == STAT_OK))
      else $error("fill requested with an error status");

endmodule

bind block_cache_lru_refcount bclru_checker u_bclru_checker (.*);

>>> verif/tb_block_cache_lru_refcount.sv
`timescale 1ns / 1ps
// tb_block_cache_lru_refcount: self-checking testbench of the lru block buffer cache
// depends on bclru_pkg and block_cache_lru_refcount; directed table first, then random words
// every response is checked field by field against a typed row answer or the predictor
module tb_block_cache_lru_refcount;
   import bclru_pkg::*;

   localparam int NSLOT     = NUM_SLOTS_DEF;
   localparam int N_RANDOM  = 1000;
   localparam int POOL_SIZE = 40;          // more tags than slots, so reuse and no-free happen
   localparam int CALM_TAIL = 200;         // last random words go without idling
   localparam int DRAIN     = 4 * NSLOT + 16;

   // one response as the cache answers it
   typedef struct packed {
      logic [4:0] slot;
      logic       hit;
      logic       fill;
      logic [1:0] status;
   } answer_type;

   // one request word, with a typed answer where the row fixes one
   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  dev;
      logic [31:0] blk;
      logic [4:0]  idx;
      logic        fixed;
      answer_type  want;
   } word_type;

   // one line of the directed table; a row can repeat, optionally walking the slot index
   typedef struct {
      word_type w;
      int       reps;
      bit       stepping;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_READ;
   logic [7:0]  req_device_id = 8'd0;
   logic [31:0] req_block_number = 32'd0;
   logic [4:0]  req_slot_index = 5'd0;
   logic        rsp_valid;
   logic [4:0]  rsp_slot;
   logic        rsp_hit;
   logic        rsp_needs_fill;
   logic [1:0]  rsp_status;

   block_cache_lru_refcount #(.NUM_SLOTS(NSLOT)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_device_id(req_device_id),
      .req_block_number(req_block_number),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid),
      .rsp_slot(rsp_slot),
      .rsp_hit(rsp_hit),
      .rsp_needs_fill(rsp_needs_fill),
      .rsp_status(rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted cache contents
   logic [7:0]  tag_dev  [NSLOT];
   logic [31:0] tag_blk  [NSLOT];
   logic        line_ok  [NSLOT];
   logic [7:0]  ref_cnt  [NSLOT];
   logic [4:0]  lru_order[NSLOT];     // position 0 is most recent

   // tags the random reads draw from, so hits are common
   logic [7:0]  pool_dev[POOL_SIZE];
   logic [31:0] pool_blk[POOL_SIZE];

   answer_type due_answers[$];        // answers still owed by the cache
   row_type    dir_rows[$];

   word_type cur_word;
   bit    loaded = 1'b0;              // cur_word is on the request ports
   bit    stim_done = 1'b0;
   int    gap_left = 0;
   int    row_ptr = 0;
   int    rep_ptr = 0;
   int    rand_count = 0;
   int    words_taken = 0;
   int    errors = 0;
   int    n_read = 0, n_hit = 0, n_fill = 0;
   int    n_nofree = 0, n_under = 0, n_sat = 0;

   task automatic cache_clear();
      for (int i = 0; i < NSLOT; i++) begin
         tag_dev[i]   = 8'd0;
         tag_blk[i]   = 32'd0;
         line_ok[i]   = 1'b0;
         ref_cnt[i]   = 8'd0;
         lru_order[i] = 5'(NSLOT - 1 - i);
      end
   endtask

   // applies one word to the predictor and returns the answer it must produce
   function automatic answer_type cache_apply(input word_type w);
      answer_type a;
      int pos;
      int j;
      logic [4:0] s;
      bit found;
      a.slot   = w.idx;
      a.hit    = 1'b0;
      a.fill   = 1'b0;
      a.status = STAT_OK;
      found = 1'b0;
      s = 5'd0;
      if (w.action == ACT_READ) begin
         // hit scan, most recent first
         for (pos = 0; pos < NSLOT; pos++)
            if (!found && tag_dev[lru_order[pos]] == w.dev &&
                tag_blk[lru_order[pos]] == w.blk) begin
               s = lru_order[pos];
               found = 1'b1;
            end
         if (found) begin
            a.slot = s;
            a.hit  = 1'b1;
            if (ref_cnt[s] >= COUNT_MAX) begin
               a.status = STAT_SAT;
            end else begin
               ref_cnt[s] = ref_cnt[s] + 8'd1;
               if (!line_ok[s]) begin
                  a.fill = 1'b1;
                  line_ok[s] = 1'b1;
               end
            end
         end else begin
            // free scan, least recent first
            for (pos = NSLOT - 1; pos >= 0; pos--)
               if (!found && ref_cnt[lru_order[pos]] == 8'd0) begin
                  s = lru_order[pos];
                  found = 1'b1;
               end
            if (found) begin
               tag_dev[s] = w.dev;
               tag_blk[s] = w.blk;
               ref_cnt[s] = 8'd1;
               line_ok[s] = 1'b1;
               a.slot = s;
               a.fill = 1'b1;
            end else begin
               a.slot   = 5'd0;
               a.status = STAT_NOFREE;
            end
         end
      end else if (w.action == ACT_PIN) begin
         if (ref_cnt[w.idx] >= COUNT_MAX) a.status = STAT_SAT;
         else ref_cnt[w.idx] = ref_cnt[w.idx] + 8'd1;
      end else if (ref_cnt[w.idx] == 8'd0) begin
         a.status = STAT_UNDER;
      end else begin
         ref_cnt[w.idx] = ref_cnt[w.idx] - 8'd1;
         // last release of a slot makes it the most recent
         if (w.action == ACT_RELEASE && ref_cnt[w.idx] == 8'd0) begin
            pos = 0;
            while (pos < NSLOT && lru_order[pos] != w.idx) pos++;
            if (pos < NSLOT) begin
               for (j = pos; j > 0; j--) lru_order[j] = lru_order[j - 1];
               lru_order[0] = w.idx;
            end
         end
      end
      return a;
   endfunction

   // random word; fill-heavy and drain-heavy stretches alternate so the
   // cache runs both nearly empty and out of free slots
   function automatic word_type random_word(input int n);
      word_type w;
      int r;
      int k;
      int off;
      int read_pct;
      bit got_slot;
      w.action = 2'($urandom_range(0, 3));
      w.dev    = 8'($urandom);
      w.blk    = $urandom;
      w.idx    = 5'($urandom);
      w.fixed  = 1'b0;
      w.want   = '0;
      read_pct = ((n / 150) % 2 == 0) ? 55 : 25;
      r = $urandom_range(0, 99);
      if (r < read_pct) begin
         w.action = ACT_READ;
         if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, POOL_SIZE - 1);
            w.dev = pool_dev[k];
            w.blk = pool_blk[k];
         end
      end else if (r < 96) begin
         if (r < 80) w.action = ACT_RELEASE;
         else if (r < 88) w.action = ACT_PIN;
         else w.action = ACT_UNPIN;
         // mostly act on a slot that is actually held
         if ($urandom_range(0, 99) < 85) begin
            off = $urandom_range(0, NSLOT - 1);
            got_slot = 1'b0;
            for (k = 0; k < NSLOT; k++)
               if (!got_slot && ref_cnt[(off + k) % NSLOT] != 8'd0) begin
                  w.idx = 5'((off + k) % NSLOT);
                  got_slot = 1'b1;
               end
         end
      end
      // remaining few percent: fully random noise
      return w;
   endfunction

   // next word of the run: table rows first, then random words
   function automatic bit next_word(output word_type w);
      if (row_ptr < dir_rows.size()) begin
         w = dir_rows[row_ptr].w;
         if (dir_rows[row_ptr].stepping) w.idx = 5'(w.idx + rep_ptr);
         rep_ptr++;
         if (rep_ptr >= dir_rows[row_ptr].reps) begin
            rep_ptr = 0;
            row_ptr++;
         end
         return 1'b1;
      end
      if (rand_count < N_RANDOM) begin
         w = random_word(rand_count);
         rand_count++;
         return 1'b1;
      end
      w = '0;
      return 1'b0;
   endfunction

   // idle level changes every hundred random words; none at the tail
   function automatic bit go_idle();
      int level;
      if (row_ptr < dir_rows.size()) level = 1;
      else if (rand_count >= N_RANDOM - CALM_TAIL) level = 0;
      else level = (rand_count / 100) % 3;
      if (level == 0) return 1'b0;
      if (level == 1) return $urandom_range(0, 3) == 0;
      return $urandom_range(0, 1) == 0;
   endfunction

   task automatic add_row(input logic [1:0] act, input logic [7:0] dev, input logic [31:0] blk,
                          input logic [4:0] idx, input int reps, input bit stepping,
                          input bit fixed, input logic [4:0] xslot, input logic xhit,
                          input logic xfill, input logic [1:0] xstat);
      row_type r;
      r.w.action      = act;
      r.w.dev         = dev;
      r.w.blk         = blk;
      r.w.idx         = idx;
      r.w.fixed       = fixed;
      r.w.want.slot   = xslot;
      r.w.want.hit    = xhit;
      r.w.want.fill   = xfill;
      r.w.want.status = xstat;
      r.reps          = reps;
      r.stepping      = stepping;
      dir_rows.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   // request side: a word is taken at an edge with start high and busy low
   always @(posedge clock) begin : drive_words
      answer_type got;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            got = cache_apply(cur_word);
            due_answers.push_back(cur_word.fixed ? cur_word.want : got);
            words_taken++;
            loaded = 1'b0;
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (!loaded && !stim_done) begin
            if (go_idle()) gap_left = $urandom_range(0, 11);
            else if (next_word(cur_word)) loaded = 1'b1;
            else stim_done = 1'b1;
         end
         // start stays high across back-to-back words: one assignment per edge
         start            <= loaded;
         req_action       <= cur_word.action;
         req_device_id    <= cur_word.dev;
         req_block_number <= cur_word.blk;
         req_slot_index   <= cur_word.idx;
      end
   end

   // response side: the strobe cannot be held off, so every strobe is checked
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid) begin
         if (due_answers.size() == 0) begin
            report_mismatch($sformatf(
               "response with none due: slot %0d hit %0b fill %0b status %0d",
               rsp_slot, rsp_hit, rsp_needs_fill, rsp_status));
         end else begin
            want = due_answers.pop_front();
            if (rsp_slot !== want.slot || rsp_hit !== want.hit ||
                rsp_needs_fill !== want.fill || rsp_status !== want.status)
               report_mismatch($sformatf(
                  "slot %0d/%0d hit %0b/%0b fill %0b/%0b status %0d/%0d (got/exp)",
                  rsp_slot, want.slot, rsp_hit, want.hit,
                  rsp_needs_fill, want.fill, rsp_status, want.status));
            if (want.status == STAT_NOFREE) n_nofree++;
            if (want.status == STAT_UNDER) n_under++;
            if (want.status == STAT_SAT) n_sat++;
            if (want.hit) n_hit++;
            if (want.fill) n_fill++;
         end
      end
      if (!reset && start && !busy && req_action == ACT_READ) n_read++;
   end

   initial begin
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_dev[k] = 8'($urandom);
         pool_blk[k] = $urandom;
      end
      // extreme tags in the pool
      pool_dev[0] = 8'h00; pool_blk[0] = 32'h0000_0000;
      pool_dev[1] = 8'hff; pool_blk[1] = 32'hffff_ffff;
      pool_dev[2] = 8'h00; pool_blk[2] = 32'hffff_ffff;
      pool_dev[3] = 8'hff; pool_blk[3] = 32'h0000_0000;

      // directed table: action, device, block, slot, repeat, walk slot, typed answer
      // tag zero after reset: hits the most recent slot and still needs a fill
      add_row(ACT_READ,    8'h00, 32'h0000_0000,  0,   1, 0, 1, 31, 1, 1, STAT_OK);
      add_row(ACT_RELEASE, 8'h00, 32'h0000_0000, 31,   1, 0, 1, 31, 0, 0, STAT_OK);
      // underflow on release and unpin
      add_row(ACT_RELEASE, 8'h00, 32'h0000_0000, 31,   1, 0, 1, 31, 0, 0, STAT_UNDER);
      add_row(ACT_UNPIN,   8'hff, 32'hffff_ffff,  5,   1, 0, 1,  5, 0, 0, STAT_UNDER);
      // miss takes the least recent free slot, then the same tag hits it
      add_row(ACT_READ,    8'hff, 32'hffff_ffff, 31,   1, 0, 1,  0, 0, 1, STAT_OK);
      add_row(ACT_READ,    8'hff, 32'hffff_ffff,  0,   1, 0, 1,  0, 1, 0, STAT_OK);
      add_row(ACT_PIN,     8'h00, 32'h0000_0000,  0,   1, 0, 1,  0, 0, 0, STAT_OK);
      add_row(ACT_UNPIN,   8'h00, 32'h0000_0000,  0,   1, 0, 1,  0, 0, 0, STAT_OK);
      add_row(ACT_RELEASE, 8'h00, 32'h0000_0000,  0,   1, 0, 1,  0, 0, 0, STAT_OK);
      add_row(ACT_RELEASE, 8'h00, 32'h0000_0000,  0,   1, 0, 1,  0, 0, 0, STAT_OK);
      add_row(ACT_READ,    8'h80, 32'h8000_0000, 17,   1, 0, 0,  0, 0, 0, STAT_OK);
      add_row(ACT_READ,    8'h01, 32'h0000_0001,  9,   1, 0, 0,  0, 0, 0, STAT_OK);
      // saturate slot 31, then pin and hit it at the top count
      add_row(ACT_PIN,     8'h00, 32'h0000_0000, 31, 255, 0, 0,  0, 0, 0, STAT_OK);
      add_row(ACT_PIN,     8'h00, 32'h0000_0000, 31,   1, 0, 1, 31, 0, 0, STAT_SAT);
      add_row(ACT_READ,    8'h00, 32'h0000_0000,  3,   1, 0, 1, 31, 1, 0, STAT_SAT);
      add_row(ACT_RELEASE, 8'h00, 32'h0000_0000, 31, 255, 0, 0,  0, 0, 0, STAT_OK);
      // hold every slot, then a miss finds no free slot
      add_row(ACT_PIN,     8'h00, 32'h0000_0000,  0,  32, 1, 0,  0, 0, 0, STAT_OK);
      add_row(ACT_READ,    8'h55, 32'h1234_5678, 31,   1, 0, 1,  0, 0, 0, STAT_NOFREE);
      add_row(ACT_UNPIN,   8'h00, 32'h0000_0000,  0,  32, 1, 0,  0, 0, 0, STAT_OK);
      add_row(ACT_READ,    8'h55, 32'h1234_5678, 31,   1, 0, 0,  0, 0, 0, STAT_OK);
      add_row(ACT_READ,    8'h80, 32'h8000_0000,  0,   1, 0, 0,  0, 0, 0, STAT_OK);
      add_row(ACT_UNPIN,   8'h80, 32'h8000_0000,  1,   1, 0, 0,  0, 0, 0, STAT_OK);

      cache_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!stim_done) @(posedge clock);
      while (due_answers.size() != 0) @(posedge clock);
      // nothing due; watch a while longer for stray strobes
      repeat (DRAIN) @(posedge clock);

      $display("run: %0d words (%0d random), %0d reads, %0d hits, %0d fills",
               words_taken, rand_count, n_read, n_hit, n_fill);
      $display("run: %0d no-free, %0d underflow, %0d saturated, %0d mismatches",
               n_nofree, n_under, n_sat, errors);
      if (errors == 0 && due_answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5000000;
      $display("timeout with %0d answers due", due_answers.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
hdl/bclru_pkg.sv
hdl/bclru_order_ram.sv
hdl/bclru_slot_ram.sv
hdl/block_cache_lru_refcount.sv
hdl/bclru_checker.sv
verif/tb_block_cache_lru_refcount.sv
